/* hdl/trg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle route generator package
// Shared constants, register codes and the types passed between the units.
// ----------------------------------------------------------------------------
package trg_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int TICK_W     = 16;
	localparam int DIV_NW     = 66;
	localparam int DIV_DW     = 34;
	localparam int CNT_W      = 7;
	localparam int MUL_STEPS  = 33;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_V1X, REG_V2X, REG_V3X, REG_BASE_Y, REG_APEX_Y, REG_TICK
	} cfg_reg_e;

	typedef struct packed {
		logic signed [31:0] v1x;
		logic signed [31:0] v2x;
		logic signed [31:0] v3x;
		logic signed [31:0] base_y;
		logic signed [31:0] apex_y;
		logic [TICK_W-1:0]  tick;
	} cfg_t;

	typedef struct packed {
		logic [31:0] speed;
		logic        recompute;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SETUP, ST_DIV, ST_MUL, ST_STORE, ST_TICK, ST_MULT_L, ST_ADD_L, ST_OUT
	} back_state_e;

	typedef enum logic [3:0] {
		OP_T1, OP_MA, OP_DA, OP_MB, OP_DB, OP_K0, OP_K1, OP_K3, OP_K2, OP_K4, OP_DONE
	} op_e;

endpackage

/* hdl/trg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle route generator channels
// Valid/ready channels for the speed items and the point results.
// ----------------------------------------------------------------------------
interface trg_speed_if;
	logic        valid;
	logic        ready;
	logic [31:0] speed;
	modport source (output valid, output speed, input ready);
	modport sink (input valid, input speed, output ready);
endinterface

interface trg_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_a_x;
	logic signed [31:0] point_a_y;
	logic signed [31:0] point_b_x;
	logic signed [31:0] point_b_y;
	logic               fault;
	modport source (output valid, output point_a_x, output point_a_y, output point_b_x,
		output point_b_y, output fault, input ready);
	modport sink (input valid, input point_a_x, input point_a_y, input point_b_x,
		input point_b_y, input fault, output ready);
endinterface

/* hdl/trg_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle route generator front end
// Accepts speed items and marks those that need the segment table rebuilt.
// ----------------------------------------------------------------------------
module trg_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_touch,
	trg_speed_if.sink     speed_ch,
	input  logic          full,
	output logic          push,
	output trg_pkg::job_t job
);
	import trg_pkg::*;

	logic        stale_q;
	logic [31:0] last_q;

	assign speed_ch.ready = !full;
	assign push           = speed_ch.valid && speed_ch.ready;
	assign job.speed      = speed_ch.speed;
	assign job.recompute  = stale_q || (speed_ch.speed != last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_q <= 1'b1;
			last_q  <= '0;
		end else if (cfg_touch) begin
			stale_q <= 1'b1;
		end else if (push) begin
			stale_q <= 1'b0;
			last_q  <= speed_ch.speed;
		end
	end
endmodule

/* hdl/trg_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle route generator job queue
// Short queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module trg_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  trg_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output trg_pkg::job_t dout
);
	import trg_pkg::*;

	job_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full      = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign not_empty = cnt_q != '0;
	assign dout      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

/* hdl/trg_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle route generator back end
// Rebuilds segment times and slopes with a serial divider and multiplier,
// advances both phase timers and interpolates the two points.
// ----------------------------------------------------------------------------
module trg_back (
	input  logic          clk,
	input  logic          arst_n,
	input  trg_pkg::cfg_t cfg,
	input  logic          job_valid,
	input  trg_pkg::job_t job,
	output logic          pop,
	trg_point_if.source   point_ch
);
	import trg_pkg::*;

	back_state_e state_q, state_d;
	op_e         op_q;
	logic        out_load;

	job_t               job_q;
	logic [31:0]        t1_q, t2_q, t3_q, ta_q, tb_q;
	logic signed [31:0] slope_q [5];
	logic               started_q, fault_q;

	logic [DIV_NW-1:0] dnum_q, dquo_q, macc_q, mcand_q;
	logic [DIV_DW-1:0] dden_q;
	logic [DIV_DW-1:0] drem_q;
	logic [32:0]       mplier_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              dneg_q;

	logic [1:0]         lidx_q;
	logic [63:0]        prod_s1;
	logic signed [31:0] anchor_s1;
	logic               neg_s1;
	logic signed [31:0] res_q [4];
	logic               out_valid_q;

	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

	function automatic logic [31:0] sat_u32(input logic [DIV_NW-1:0] v);
		return (|v[DIV_NW-1:32]) ? '1 : v[31:0];
	endfunction

	function automatic logic signed [31:0] slope_sat(input logic [DIV_NW-1:0] q, input logic n);
		logic signed [31:0] r;
		if (n) begin
			r = (q > DIV_NW'(33'h080000000)) ? 32'sh80000000 : 32'(~q[31:0] + 32'd1);
		end else begin
			r = (q > DIV_NW'(33'h07FFFFFFF)) ? 32'sh7FFFFFFF : q[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] advance(input logic [31:0] t, input logic [31:0] t3,
		input logic [TICK_W-1:0] tick);
		logic [32:0] s;
		s = {1'b0, t} + 33'(tick);
		return (s > {1'b0, t3}) ? '0 : s[31:0];
	endfunction

	// Operand selection for the rebuild steps
	logic signed [32:0] e21, e32, e13, eyh, eyl;
	logic [32:0]        d12, ra, rb;
	logic [33:0]        rsum;
	logic               op_skip, op_mul, op_neg;
	logic [DIV_NW-1:0]  op_num;
	logic [DIV_DW-1:0]  op_den;

	assign e21  = 33'(cfg.v2x) - 33'(cfg.v1x);
	assign e32  = 33'(cfg.v3x) - 33'(cfg.v2x);
	assign e13  = 33'(cfg.v1x) - 33'(cfg.v3x);
	assign eyh  = 33'(cfg.apex_y) - 33'(cfg.base_y);
	assign eyl  = 33'(cfg.base_y) - 33'(cfg.apex_y);
	assign d12  = mag33(e21);
	assign ra   = mag33(e32);
	assign rb   = mag33(e13);
	assign rsum = 34'(ra) + 34'(rb);

	always_comb begin
		op_skip = 1'b0;
		op_mul  = 1'b0;
		op_neg  = 1'b0;
		op_num  = '0;
		op_den  = '0;
		unique case (op_q)
			OP_T1: begin
				op_skip = job_q.speed == '0;
				op_num  = DIV_NW'({d12, {FRAC_BITS{1'b0}}});
				op_den  = DIV_DW'(job_q.speed);
			end
			OP_MA, OP_MB: begin
				op_skip = rsum == '0;
				op_mul  = 1'b1;
			end
			OP_DA, OP_DB: begin
				op_skip = rsum == '0;
				op_num  = macc_q;
				op_den  = rsum;
			end
			OP_K0: begin
				op_skip = t1_q == '0;
				op_num  = DIV_NW'({mag33(e21), {FRAC_BITS{1'b0}}});
				op_neg  = e21[32];
				op_den  = DIV_DW'(t1_q);
			end
			OP_K1: begin
				op_skip = !(t2_q > t1_q);
				op_num  = DIV_NW'({mag33(e32), {FRAC_BITS{1'b0}}});
				op_neg  = e32[32];
				op_den  = DIV_DW'(t2_q - t1_q);
			end
			OP_K3: begin
				op_skip = !(t2_q > t1_q);
				op_num  = DIV_NW'({mag33(eyh), {FRAC_BITS{1'b0}}});
				op_neg  = eyh[32];
				op_den  = DIV_DW'(t2_q - t1_q);
			end
			OP_K2: begin
				op_skip = !(t3_q > t2_q);
				op_num  = DIV_NW'({mag33(e13), {FRAC_BITS{1'b0}}});
				op_neg  = e13[32];
				op_den  = DIV_DW'(t3_q - t2_q);
			end
			OP_K4: begin
				op_skip = !(t3_q > t2_q);
				op_num  = DIV_NW'({mag33(eyl), {FRAC_BITS{1'b0}}});
				op_neg  = eyl[32];
				op_den  = DIV_DW'(t3_q - t2_q);
			end
			default: begin
				op_skip = 1'b0;
			end
		endcase
	end

	// One restoring division step
	logic [DIV_DW:0]   rem_sh;
	logic              qbit;
	logic [DIV_DW-1:0] rem_next;

	always_comb begin
		rem_sh   = {drem_q, dnum_q[DIV_NW-1]};
		qbit     = rem_sh >= {1'b0, dden_q};
		rem_next = qbit ? DIV_DW'(rem_sh - {1'b0, dden_q}) : rem_sh[DIV_DW-1:0];
	end

	// Interpolation operands
	logic [31:0]        lt, ldt, lmag;
	logic signed [31:0] lanchor, lslope;
	logic               ly;

	always_comb begin
		lt = lidx_q[1] ? tb_q : ta_q;
		ly = lidx_q[0];
		priority if (fault_q) begin
			lanchor = ly ? cfg.base_y : cfg.v1x;
			lslope  = '0;
			ldt     = '0;
		end else if (lt < t1_q) begin
			lanchor = ly ? cfg.base_y : cfg.v1x;
			lslope  = ly ? 32'sd0 : slope_q[0];
			ldt     = lt;
		end else if (lt < t2_q) begin
			lanchor = ly ? cfg.base_y : cfg.v2x;
			lslope  = ly ? slope_q[3] : slope_q[1];
			ldt     = lt - t1_q;
		end else if (lt < t3_q) begin
			lanchor = ly ? cfg.apex_y : cfg.v3x;
			lslope  = ly ? slope_q[4] : slope_q[2];
			ldt     = lt - t2_q;
		end else begin
			lanchor = ly ? cfg.base_y : cfg.v1x;
			lslope  = '0;
			ldt     = '0;
		end
		lmag = lslope[31] ? 32'(-lslope) : 32'(lslope);
	end

	logic signed [65:0] lsum;
	logic signed [31:0] lres;

	always_comb begin
		lsum = neg_s1 ? 66'(anchor_s1) - $signed({2'b0, prod_s1 >> FRAC_BITS})
			: 66'(anchor_s1) + $signed({2'b0, prod_s1 >> FRAC_BITS});
		if (!lsum[65] && (|lsum[64:31])) begin
			lres = 32'sh7FFFFFFF;
		end else if (lsum[65] && !(&lsum[64:31])) begin
			lres = 32'sh80000000;
		end else begin
			lres = lsum[31:0];
		end
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					state_d = job.recompute ? ST_SETUP : ST_TICK;
				end
			end
			ST_SETUP: begin
				if (op_q == OP_DONE) begin
					state_d = ST_TICK;
				end else if (!op_skip) begin
					state_d = op_mul ? ST_MUL : ST_DIV;
				end
			end
			ST_DIV, ST_MUL: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE:  state_d = ST_SETUP;
			ST_TICK:   state_d = ST_MULT_L;
			ST_MULT_L: state_d = ST_ADD_L;
			ST_ADD_L:  state_d = (lidx_q == 2'd3) ? ST_OUT : ST_MULT_L;
			ST_OUT: begin
				if (!out_valid_q || point_ch.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = (state_q == ST_IDLE) && job_valid;
		out_load = (state_q == ST_OUT) && (!out_valid_q || point_ch.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_T1;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
			ta_q        <= '0;
			tb_q        <= '0;
			t1_q        <= '0;
			t2_q        <= '0;
			t3_q        <= '0;
			for (int i = 0; i < 5; i++) begin
				slope_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (point_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && job.recompute) begin
						op_q <= OP_T1;
						t1_q <= '0;
						t2_q <= '0;
						t3_q <= '0;
						for (int i = 0; i < 5; i++) begin
							slope_q[i] <= '0;
						end
					end
				end
				ST_SETUP: begin
					if (op_q != OP_DONE && op_skip) begin
						op_q <= op_e'(op_q + 1'b1);
					end
				end
				ST_STORE: begin
					op_q <= op_e'(op_q + 1'b1);
					unique case (op_q)
						OP_T1: begin
							t1_q <= sat_u32(dquo_q);
							t2_q <= sat_u32(dquo_q);
							t3_q <= sat_u32(dquo_q);
						end
						OP_DA: t2_q <= sat_u32(DIV_NW'(t1_q) + dquo_q);
						OP_DB: t3_q <= sat_u32(DIV_NW'(t2_q) + dquo_q);
						OP_K0: slope_q[0] <= slope_sat(dquo_q, dneg_q);
						OP_K1: slope_q[1] <= slope_sat(dquo_q, dneg_q);
						OP_K2: slope_q[2] <= slope_sat(dquo_q, dneg_q);
						OP_K3: slope_q[3] <= slope_sat(dquo_q, dneg_q);
						OP_K4: slope_q[4] <= slope_sat(dquo_q, dneg_q);
						default: ;
					endcase
				end
				ST_TICK: begin
					started_q <= 1'b1;
					ta_q      <= advance(ta_q, t3_q, cfg.tick);
					tb_q      <= advance(started_q ? tb_q : t1_q, t3_q, cfg.tick);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
		unique case (state_q)
			ST_SETUP: begin
				dnum_q   <= op_num;
				dden_q   <= op_den;
				dneg_q   <= op_neg;
				drem_q   <= '0;
				dquo_q   <= '0;
				macc_q   <= op_mul ? '0 : macc_q;
				mcand_q  <= DIV_NW'(t1_q);
				mplier_q <= (op_q == OP_MA) ? ra : rb;
				cnt_q    <= op_mul ? CNT_W'(MUL_STEPS) : CNT_W'(DIV_NW);
			end
			ST_DIV: begin
				drem_q <= rem_next;
				dnum_q <= {dnum_q[DIV_NW-2:0], 1'b0};
				dquo_q <= {dquo_q[DIV_NW-2:0], qbit};
				cnt_q  <= cnt_q - 1'b1;
			end
			ST_MUL: begin
				if (mplier_q[0]) begin
					macc_q <= macc_q + mcand_q;
				end
				mcand_q  <= {mcand_q[DIV_NW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[32:1]};
				cnt_q    <= cnt_q - 1'b1;
			end
			ST_TICK: begin
				lidx_q  <= '0;
				fault_q <= (t1_q == '0) || (t2_q == t1_q) || (t3_q == t2_q);
			end
			ST_MULT_L: begin
				prod_s1   <= 64'(lmag) * 64'(ldt);
				anchor_s1 <= lanchor;
				neg_s1    <= lslope[31];
			end
			ST_ADD_L: begin
				res_q[lidx_q] <= lres;
				lidx_q        <= lidx_q + 1'b1;
			end
			ST_OUT: begin
				if (out_load) begin
					point_ch.point_a_x <= res_q[0];
					point_ch.point_a_y <= res_q[1];
					point_ch.point_b_x <= res_q[2];
					point_ch.point_b_y <= res_q[3];
					point_ch.fault     <= fault_q;
				end
			end
			default: ;
		endcase
	end

	assign point_ch.valid = out_valid_q;

`ifndef SYNTH
	a_times_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TICK |-> (t2_q >= t1_q) && (t3_q >= t2_q))
		else $error("segment end times out of order");
	a_timers_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) == ST_TICK && state_q == ST_MULT_L |-> (ta_q <= t3_q) && (tb_q <= t3_q))
		else $error("phase timer beyond the last segment end");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result presented outside the output step");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == ST_SETUP || state_q == ST_TICK)
		else $error("job taken without starting its work");
`endif
endmodule

/* hdl/triangle_route_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle route generator
// Two phase-offset points walking a triangular path, one result per speed item.
// ----------------------------------------------------------------------------
// An item whose speed equals the previous one, with no register written since,
// takes a timer step, four interpolations through one 32 by 32 multiplier, each
// in a multiply state and an add state, and the output load. A new speed or a
// register write rebuilds the segment table first, through a one-bit-a-cycle
// divider (up to eight quotients: the first segment time, the two shares of it
// and the five slopes) and a serial multiplier (two products).
// A two-entry queue and the output register let both sides stall.
module triangle_route_generator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [trg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data,
	trg_speed_if.sink                         speed_ch,
	trg_point_if.source                       point_ch
);
	import trg_pkg::*;

	cfg_t cfg_q;
	logic cfg_touch;
	logic push, full, pop, not_empty;
	job_t job_in, job_out;

	assign cfg_touch = cfg_we && (cfg_index <= CFG_IDX_W'(REG_TICK));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.v1x    <= 32'sd0;
			cfg_q.v2x    <= 32'sd65536;
			cfg_q.v3x    <= 32'sd32768;
			cfg_q.base_y <= 32'sd0;
			cfg_q.apex_y <= 32'sd32768;
			cfg_q.tick   <= TICK_W'(66);
		end else if (cfg_we) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_V1X:    cfg_q.v1x    <= cfg_data;
				REG_V2X:    cfg_q.v2x    <= cfg_data;
				REG_V3X:    cfg_q.v3x    <= cfg_data;
				REG_BASE_Y: cfg_q.base_y <= cfg_data;
				REG_APEX_Y: cfg_q.apex_y <= cfg_data;
				REG_TICK:   cfg_q.tick   <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	trg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_touch(cfg_touch),
		.speed_ch (speed_ch),
		.full     (full),
		.push     (push),
		.job      (job_in)
	);

	trg_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (job_in),
		.full     (full),
		.pop      (pop),
		.not_empty(not_empty),
		.dout     (job_out)
	);

	trg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.job_valid(not_empty),
		.job      (job_out),
		.pop      (pop),
		.point_ch (point_ch)
	);
endmodule
